// File: hdl/lca_pkg.sv
// Shared constants, types and the next-generation row function for the life grid.
package lca_pkg;

   localparam int MAX_ROWS  = 128;
   localparam int MAX_COLS  = 128;
   localparam int ADDR_W    = $clog2(MAX_ROWS);
   localparam int CIDX_W    = $clog2(MAX_COLS);
   localparam int DIM_W     = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
   localparam int CFG_W     = 8;
   localparam int WIDE_W    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam int GEN_W     = 16;
   localparam int OP_W      = 2;
   localparam int COORD_W   = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 2'd1;

   typedef logic [MAX_COLS-1:0] row_type;

   // B3/S23 on one row; columns outside the mask keep their stored value
   function automatic row_type lca_next_row(row_type prev, row_type cur, row_type nxt,
                                            row_type mask);
      row_type pm;
      row_type cm;
      row_type nm;
      row_type pw;
      row_type pe;
      row_type cw;
      row_type ce;
      row_type nw;
      row_type ne;
      row_type res;
      logic [3:0] n;
      pm = prev & mask;
      cm = cur & mask;
      nm = nxt & mask;
      pw = pm << 1;
      pe = pm >> 1;
      cw = cm << 1;
      ce = cm >> 1;
      nw = nm << 1;
      ne = nm >> 1;
      res = cur;
      for (int c = 0; c < MAX_COLS; c++) begin
         n = {3'b0, pw[c]} + {3'b0, pm[c]} + {3'b0, pe[c]} + {3'b0, cw[c]}
           + {3'b0, ce[c]} + {3'b0, nw[c]} + {3'b0, nm[c]} + {3'b0, ne[c]};
         if (mask[c]) begin
            res[c] = (n == 4'd3) || (cur[c] && (n == 4'd2));
         end
      end
      return res;
   endfunction

endpackage

// File: hdl/lca_ram.sv
// Generic simple dual-port RAM with registered read.
module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/life_cellular_automaton_step.sv
// Top level: B3/S23 life grid held in a row-wide RAM, with cell write/read and generation step.
// Write and read: RAM row read at accept; in ST_ACC the row is merged or read and the result registered.
// Generation step: ST_GFILL takes the first row, then ST_GRUN writes one grid row per cycle;
//   the result is registered with the last row, rows being rows_in_use clamped to 1..128.
// One request at a time; the next is accepted no earlier than the edge that takes the result.
// Reset (sync): row valid bits clear so the grid reads dead, generation to 0, sizes to 128.
module life_cellular_automaton_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lca_pkg::OP_W-1:0]         req_opcode,
   input  logic [lca_pkg::COORD_W-1:0]      req_row,
   input  logic [lca_pkg::COORD_W-1:0]      req_col,
   input  logic                             req_alive_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_alive_out,
   output logic                             rsp_in_range,
   output logic [lca_pkg::GEN_W-1:0]        rsp_generation,
   input  logic                             csr_wr_en,
   input  logic [lca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lca_pkg::CFG_W-1:0]        csr_wr_data
);
   import lca_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ACC   = 2'd1;
   localparam logic [1:0] ST_GFILL = 2'd2;
   localparam logic [1:0] ST_GRUN  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CFG_W-1:0]    rows_cfg_ff, cols_cfg_ff;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [CIDX_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                alive_ff, alive_in;
   logic                inside_ff, inside_in;
   logic                rd_hit_ff, rd_hit_in;
   logic [MAX_ROWS-1:0] row_valid_ff, row_valid_in;
   row_type             prev_ff, prev_in;
   row_type             cur_ff, cur_in;
   logic [WIDE_W-1:0]   cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_alive_ff, rsp_alive_in;
   logic                rsp_in_range_ff, rsp_in_range_in;
   logic [GEN_W-1:0]    rsp_gen_ff, rsp_gen_in;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   row_type             ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   row_type             ram_rd_data;

   logic [WIDE_W-1:0]   nr, nc;
   logic [WIDE_W-1:0]   rows_ext, cols_ext;
   logic [WIDE_W-1:0]   row_ext, col_ext;
   row_type             col_mask;
   row_type             q_eff;
   row_type             mod_row;
   logic                in_grid;
   logic [WIDE_W:0]     next_rd;
   logic [ADDR_W-1:0]   next_rd_addr;
   logic                req_fire;

   lca_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rows_ext = WIDE_W'(rows_cfg_ff);
      cols_ext = WIDE_W'(cols_cfg_ff);
      if (rows_ext == '0) begin
         nr = WIDE_W'(1);
      end else if (rows_ext > WIDE_W'(MAX_ROWS)) begin
         nr = WIDE_W'(MAX_ROWS);
      end else begin
         nr = rows_ext;
      end
      if (cols_ext == '0) begin
         nc = WIDE_W'(1);
      end else if (cols_ext > WIDE_W'(MAX_COLS)) begin
         nc = WIDE_W'(MAX_COLS);
      end else begin
         nc = cols_ext;
      end
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = WIDE_W'(c) < nc;
      end
   end

   assign row_ext   = WIDE_W'(req_row);
   assign col_ext   = WIDE_W'(req_col);
   assign in_grid   = (row_ext < nr) && (col_ext < nc);
   assign q_eff     = rd_hit_ff ? ram_rd_data : '0;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign next_rd   = {1'b0, cnt_ff} + ((state_ff == ST_GFILL) ? (WIDE_W+1)'(1)
                                                               : (WIDE_W+1)'(2));
   assign next_rd_addr = next_rd[ADDR_W-1:0];

   always_comb begin
      state_in        = state_ff;
      gen_in          = gen_ff;
      op_in           = op_ff;
      col_in          = col_ff;
      addr_in         = addr_ff;
      alive_in        = alive_ff;
      inside_in       = inside_ff;
      rd_hit_in       = 1'b0;
      prev_in         = prev_ff;
      cur_in          = cur_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_alive_in    = rsp_alive_ff;
      rsp_in_range_in = rsp_in_range_ff;
      rsp_gen_in      = rsp_gen_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = addr_ff;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = '0;
      mod_row         = q_eff;
      mod_row[col_ff] = alive_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_ADVANCE) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  rd_hit_in   = row_valid_ff[0];
                  prev_in     = '0;
                  cnt_in      = '0;
                  state_in    = ST_GFILL;
               end else begin
                  op_in       = req_opcode;
                  col_in      = col_ext[CIDX_W-1:0];
                  addr_in     = row_ext[ADDR_W-1:0];
                  alive_in    = req_alive_in;
                  inside_in   = in_grid;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = row_ext[ADDR_W-1:0];
                  rd_hit_in   = row_valid_ff[row_ext[ADDR_W-1:0]];
                  state_in    = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            rsp_valid_in    = 1'b1;
            rsp_alive_in    = 1'b0;
            rsp_in_range_in = 1'b0;
            rsp_gen_in      = gen_ff;
            if (inside_ff) begin
               unique case (op_ff)
                  OP_WRITE: begin
                     ram_wr_en       = 1'b1;
                     ram_wr_addr     = addr_ff;
                     ram_wr_data     = mod_row;
                     rsp_alive_in    = alive_ff;
                     rsp_in_range_in = 1'b1;
                  end
                  OP_READ: begin
                     rsp_alive_in    = q_eff[col_ff];
                     rsp_in_range_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            state_in = ST_IDLE;
         end
         ST_GFILL: begin
            cur_in      = q_eff;
            ram_rd_en   = 1'b1;
            ram_rd_addr = next_rd_addr;
            rd_hit_in   = (next_rd < {1'b0, nr}) && row_valid_ff[next_rd_addr];
            state_in    = ST_GRUN;
         end
         ST_GRUN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[ADDR_W-1:0];
            ram_wr_data = lca_next_row(prev_ff, cur_ff, q_eff, col_mask);
            prev_in     = cur_ff;
            cur_in      = q_eff;
            if (cnt_ff == nr - WIDE_W'(1)) begin
               gen_in          = gen_ff + GEN_W'(1);
               rsp_valid_in    = 1'b1;
               rsp_alive_in    = 1'b0;
               rsp_in_range_in = 1'b0;
               rsp_gen_in      = gen_ff + GEN_W'(1);
               state_in        = ST_IDLE;
            end else begin
               cnt_in      = cnt_ff + WIDE_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_rd_addr;
               rd_hit_in   = (next_rd < {1'b0, nr}) && row_valid_ff[next_rd_addr];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      row_valid_in = row_valid_ff;
      if (ram_wr_en) begin
         row_valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_hit_ff    <= 1'b0;
         rows_cfg_ff  <= CFG_W'(128);
         cols_cfg_ff  <= CFG_W'(128);
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_hit_ff    <= rd_hit_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_ROWS: rows_cfg_ff <= csr_wr_data;
               REG_COLS: cols_cfg_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      col_ff          <= col_in;
      addr_ff         <= addr_in;
      alive_ff        <= alive_in;
      inside_ff       <= inside_in;
      prev_ff         <= prev_in;
      cur_ff          <= cur_in;
      cnt_ff          <= cnt_in;
      rsp_alive_ff    <= rsp_alive_in;
      rsp_in_range_ff <= rsp_in_range_in;
      rsp_gen_ff      <= rsp_gen_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alive_out  = rsp_alive_ff;
   assign rsp_in_range   = rsp_in_range_ff;
   assign rsp_generation = rsp_gen_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request accepted while busy");

   a_wr_states: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ((state_ff == ST_ACC) || (state_ff == ST_GRUN)))
      else $error("grid write outside a write or sweep state");

   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(gen_ff) |-> ($past(state_ff) == ST_GRUN))
      else $error("generation count moved outside a sweep");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACC) || (state_ff == ST_GRUN)) |-> !rsp_valid_ff)
      else $error("result register busy while a result is produced");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRUN) |-> (cnt_ff < nr))
      else $error("sweep row beyond grid in use");

endmodule
